// ----- src/wld_pkg.sv -----
// ----------------------------------------------------------------------------
// wld_pkg - shared definitions for the window local dependence block
// Field widths, window neighbour tables and the control word that travels
// down the pipeline next to each window.
// ----------------------------------------------------------------------------
package wld_pkg;

    // field widths fixed by the stream format
    localparam int RAW_BITS       = 16;
    localparam int CELLS          = 9;
    localparam int NB_LANES       = 8;
    localparam int LANES          = NB_LANES + 1;
    localparam int CENTRE_CELL    = 4;
    localparam int CENTRE_LANE    = NB_LANES;
    localparam int MASK_BITS      = 9;
    localparam int VALUE_BITS     = 38;
    localparam int DATA_IN_BITS   = CELLS * RAW_BITS;
    localparam int DATA_OUT_BITS  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int SAMPLE_BITS_DEF = 16;

    // per neighbour lane: window cell, count of window neighbours, the list
    localparam int NB_CELL  [NB_LANES] = '{0, 1, 2, 3, 5, 6, 7, 8};
    localparam int NB_COUNT [NB_LANES] = '{2, 4, 2, 4, 4, 2, 4, 2};
    localparam int NB_LIST  [NB_LANES][4] = '{
        '{1, 3, 0, 0},
        '{0, 2, 3, 5},
        '{1, 5, 0, 0},
        '{0, 1, 6, 7},
        '{1, 2, 7, 8},
        '{3, 7, 0, 0},
        '{3, 5, 6, 8},
        '{5, 7, 0, 0}
    };

    // partial sums hold up to eight samples
    function automatic int part_width(input int sb);
        return sb + 3;
    endfunction

    // accumulator: exact sum of nine scaled products, never below the output
    function automatic int acc_width(input int sb);
        return (2 * sb + 8 > VALUE_BITS) ? 2 * sb + 8 : VALUE_BITS;
    endfunction

    // scale of each lane: mean over cnt cells times four; the centre lane sum is scaled by four
    function automatic int lane_shift(input int lane);
        if (lane == CENTRE_LANE)
            return 2;
        else if (NB_COUNT[lane] == 2)
            return 1;
        else
            return 0;
    endfunction

    // control word that follows a window down the pipeline
    typedef struct packed {
        logic valid;
        logic missing;
    } wld_ctrl_t;

endpackage

// ----- src/wld_prep.sv -----
// ----------------------------------------------------------------------------
// wld_prep - sample extension and neighbour sums
// Takes the nine samples as signed values and forms, for each lane, the multiplicand
// sample and the sum of its window neighbours; registered on enable.
// ----------------------------------------------------------------------------
module wld_prep
    import wld_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [DATA_IN_BITS-1:0]                raw_data,
    output logic signed [SAMPLE_BITS-1:0]          lane_samp_reg [LANES],
    output logic signed [part_width(SAMPLE_BITS)-1:0] lane_part_reg [LANES]
);

    localparam int EXT_W  = (SAMPLE_BITS > RAW_BITS) ? SAMPLE_BITS : RAW_BITS;
    localparam int PART_W = part_width(SAMPLE_BITS);

    logic signed [SAMPLE_BITS-1:0] samp      [CELLS];
    logic signed [SAMPLE_BITS-1:0] samp_next [LANES];
    logic signed [PART_W-1:0]      part_next [LANES];

    // low SAMPLE_BITS of each raw sample, zero extended first, taken as signed
    always_comb
    begin
        logic [EXT_W-1:0] ext;
        ext = '0;
        for (int k = 0; k < CELLS; k++)
        begin
            ext     = EXT_W'(raw_data[k*RAW_BITS +: RAW_BITS]);
            samp[k] = signed'(ext[SAMPLE_BITS-1:0]);
        end
    end

    // neighbour sums per lane; centre lane takes all eight neighbours
    always_comb
    begin
        logic signed [PART_W-1:0] acc;
        logic signed [PART_W-1:0] all_nb;
        all_nb = '0;
        for (int k = 0; k < NB_LANES; k++)
        begin
            acc = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (j < NB_COUNT[k])
                    acc = acc + PART_W'(samp[NB_LIST[k][j]]);
            end
            part_next[k] = acc;
            samp_next[k] = samp[NB_CELL[k]];
            all_nb       = all_nb + PART_W'(samp[NB_CELL[k]]);
        end
        part_next[CENTRE_LANE] = all_nb;
        samp_next[CENTRE_LANE] = samp[CENTRE_CELL];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_samp_reg <= samp_next;
            lane_part_reg <= part_next;
        end
    end

endmodule

// ----- src/wld_lane.sv -----
// ----------------------------------------------------------------------------
// wld_lane - one product lane
// Multiplies a cell sample by its neighbour sum and applies the lane's
// fixed scale; product registered on enable.
// ----------------------------------------------------------------------------
module wld_lane
    import wld_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SHIFT       = 0
)
(
    input  logic                                      clk,
    input  logic                                      en,
    input  logic signed [SAMPLE_BITS-1:0]             samp,
    input  logic signed [part_width(SAMPLE_BITS)-1:0] part,
    output logic signed [acc_width(SAMPLE_BITS)-1:0]  prod_reg
);

    localparam int PROD_W = SAMPLE_BITS + part_width(SAMPLE_BITS);
    localparam int ACC_W  = acc_width(SAMPLE_BITS);

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_next;

    // exact signed product, widened then scaled
    assign prod      = samp * part;
    assign prod_next = ACC_W'(prod) <<< SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

endmodule

// ----- src/wld_merge.sv -----
// ----------------------------------------------------------------------------
// wld_merge - lane merge and result
// Two registered adder levels combine the nine lane products, then the
// total is negated, wrapped to the output width and zeroed when missing.
// ----------------------------------------------------------------------------
module wld_merge
    import wld_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                     clk,
    input  logic                                     en_tri,
    input  logic                                     en_out,
    input  wld_ctrl_t                                ctrl_tri,
    input  logic signed [acc_width(SAMPLE_BITS)-1:0] prod [LANES],
    output logic [VALUE_BITS-1:0]                    value_reg
);

    localparam int ACC_W = acc_width(SAMPLE_BITS);

    logic signed [ACC_W-1:0] tri_reg  [3];
    logic signed [ACC_W-1:0] tri_next [3];
    logic signed [ACC_W-1:0] total;
    logic [VALUE_BITS-1:0]   value_next;

    // first level: three groups of three lanes
    always_comb
    begin
        for (int g = 0; g < 3; g++)
            tri_next[g] = prod[3*g] + prod[3*g+1] + prod[3*g+2];
    end

    // second level: final sum, negate, wrap
    always_comb
    begin
        total      = -(tri_reg[0] + tri_reg[1] + tri_reg[2]);
        value_next = ctrl_tri.missing ? '0 : total[VALUE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_tri)
            tri_reg <= tri_next;
        if (en_out)
            value_reg <= value_next;
    end

endmodule

// ----- src/window_local_dependence_top.sv -----
// ----------------------------------------------------------------------------
// window_local_dependence_top - 3x3 window local dependence value
// Throughput: one window per cycle unless the output is stalled; the four
// register stages (sum, lane multipliers, two merge adder levels) each pass
// one word per cycle.
// Nine multiplier lanes work in parallel on one window.
// Reset: rst_n asynchronous, clears all stage valid flags; no memory to clear.
// ----------------------------------------------------------------------------
module window_local_dependence_top
    import wld_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // s_tdata: sample_up_left, sample_up, sample_up_right, sample_mid_left,
    //          center_sample, sample_mid_right, sample_down_left, sample_down,
    //          sample_down_right (16 bits each, lowest first)
    input  logic [DATA_IN_BITS-1:0]  s_tdata,
    // s_tuser: missing_mask [8:0]
    input  logic [MASK_BITS-1:0]     s_tuser,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // m_tdata: dependence_value [37:0], zero padding [39:38]
    output logic [DATA_OUT_BITS-1:0] m_tdata,
    // m_tuser: result_missing [0]
    output logic                     m_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready
);

    localparam int PART_W = part_width(SAMPLE_BITS);
    localparam int ACC_W  = acc_width(SAMPLE_BITS);

    wld_ctrl_t ctrl_prep_reg, ctrl_lane_reg, ctrl_tri_reg, ctrl_out_reg;
    wld_ctrl_t ctrl_in;

    logic en_prep, en_lane, en_tri, en_out;

    logic signed [SAMPLE_BITS-1:0] lane_samp [LANES];
    logic signed [PART_W-1:0]      lane_part [LANES];
    logic signed [ACC_W-1:0]       lane_prod [LANES];
    logic [VALUE_BITS-1:0]         value;

    // per-stage enables: a stage loads when empty or when it drains
    assign en_out  = !ctrl_out_reg.valid  || m_tready;
    assign en_tri  = !ctrl_tri_reg.valid  || en_out;
    assign en_lane = !ctrl_lane_reg.valid || en_tri;
    assign en_prep = !ctrl_prep_reg.valid || en_lane;
    assign s_tready = en_prep;

    assign ctrl_in.valid   = s_tvalid;
    assign ctrl_in.missing = |s_tuser;

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_prep_reg <= '0;
            ctrl_lane_reg <= '0;
            ctrl_tri_reg  <= '0;
            ctrl_out_reg  <= '0;
        end
        else
        begin
            if (en_prep)
                ctrl_prep_reg <= ctrl_in;
            if (en_lane)
                ctrl_lane_reg <= ctrl_prep_reg;
            if (en_tri)
                ctrl_tri_reg  <= ctrl_lane_reg;
            if (en_out)
                ctrl_out_reg  <= ctrl_tri_reg;
        end
    end

    wld_prep #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_prep (
        .clk           (clk),
        .en            (en_prep),
        .raw_data      (s_tdata),
        .lane_samp_reg (lane_samp),
        .lane_part_reg (lane_part)
    );

    // nine multiplier lanes: eight neighbours and the centre
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        wld_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .SHIFT       (lane_shift(k))
        ) u_lane (
            .clk      (clk),
            .en       (en_lane),
            .samp     (lane_samp[k]),
            .part     (lane_part[k]),
            .prod_reg (lane_prod[k])
        );
    end

    wld_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk       (clk),
        .en_tri    (en_tri),
        .en_out    (en_out),
        .ctrl_tri  (ctrl_tri_reg),
        .prod      (lane_prod),
        .value_reg (value)
    );

    assign m_tdata  = DATA_OUT_BITS'(value);
    assign m_tuser  = ctrl_out_reg.missing;
    assign m_tvalid = ctrl_out_reg.valid;

endmodule

// ----- src/wld_checker.sv -----
// ----------------------------------------------------------------------------
// wld_checker - port level checks for the window local dependence block
// Watches the stream ports only; bound to the top level.
// ----------------------------------------------------------------------------
module wld_checker
    import wld_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic [MASK_BITS-1:0]     s_tuser,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [DATA_OUT_BITS-1:0] m_tdata,
    input logic                     m_tuser,
    input logic                     m_tvalid,
    input logic                     m_tready
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // a missing result carries a zero value
    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("missing result with non-zero value");

    // input never stalls while the output side drains
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with free output");

    // a window with a missing cell comes out flagged if m_tready holds while it passes the pipeline
    a_missing_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser != '0) ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid && m_tuser)
        else $error("missing window not flagged at output");

endmodule

bind window_local_dependence_top wld_checker u_wld_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
